// ===== rtl/six_step_commutation_driver_top_macros.svh =====
// ----------------------------------------------------------------------------
// six-step commutation driver assertion macros
// shorthand for the concurrent checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef SIX_STEP_COMMUTATION_DRIVER_TOP_MACROS_SVH
`define SIX_STEP_COMMUTATION_DRIVER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SSCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SSCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sscd_pkg.sv =====
// ----------------------------------------------------------------------------
// sscd_pkg
// shared types, codes and commutation tables of the six-step driver
// ----------------------------------------------------------------------------
package sscd_pkg;

	// command codes
	localparam logic [1:0] FUNC_STEP  = 2'd0;
	localparam logic [1:0] FUNC_COAST = 2'd1;
	localparam logic [1:0] FUNC_FAULT = 2'd2;

	// direction codes, anything else with the top bit set is reverse
	localparam logic [1:0] DIR_ZERO = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;

	localparam logic [2:0] SECTORS   = 3'd6;
	localparam logic [2:0] HALF_TURN = 3'd3;

	localparam logic [7:0]  DUTY_MAX        = 8'd250;
	localparam logic [15:0] AUTO_RELOAD_RST = 16'd4799;

	// clamped duty times (reload + 1) stays below 2^24
	localparam int PROD_W = 24;

	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [1:0] phase_t;

	localparam phase_t PHASE_NONE = 2'd3;
	localparam phase_t PHASE_A    = 2'd0;
	localparam phase_t PHASE_B    = 2'd1;
	localparam phase_t PHASE_C    = 2'd2;

	typedef enum logic [1:0] {
		DRV_FLOAT = 2'd0,
		DRV_PWM   = 2'd1,
		DRV_LOW   = 2'd2
	} drive_t;

	typedef struct packed {
		phase_t      high;
		phase_t      low;
		logic [15:0] compare;
		logic [7:0]  duty;
		logic        oe_set;
		logic        oe_clr;
		logic        changed;
	} step_res_t;

	// forward table: phase switched by pwm on its high side
	function automatic phase_t pwm_phase_of(input logic [2:0] idx);
		phase_t p;
		unique case (idx)
			3'd0:    p = PHASE_B;
			3'd1:    p = PHASE_C;
			3'd2:    p = PHASE_C;
			3'd3:    p = PHASE_A;
			3'd4:    p = PHASE_A;
			3'd5:    p = PHASE_B;
			default: p = PHASE_NONE;
		endcase
		return p;
	endfunction

	// forward table: phase whose low side is held on
	function automatic phase_t low_phase_of(input logic [2:0] idx);
		phase_t p;
		unique case (idx)
			3'd0:    p = PHASE_A;
			3'd1:    p = PHASE_A;
			3'd2:    p = PHASE_B;
			3'd3:    p = PHASE_B;
			3'd4:    p = PHASE_C;
			3'd5:    p = PHASE_C;
			default: p = PHASE_NONE;
		endcase
		return p;
	endfunction

	function automatic drive_t phase_mode(input phase_t hi, input phase_t lo,
		input phase_t p);
		drive_t d;
		if (hi == p) begin
			d = DRV_PWM;
		end else if (lo == p) begin
			d = DRV_LOW;
		end else begin
			d = DRV_FLOAT;
		end
		return d;
	endfunction

endpackage

// ===== rtl/sscd_step.sv =====
// ----------------------------------------------------------------------------
// sscd_step
// decodes one command into the next drive pattern, duty and compare value
// ----------------------------------------------------------------------------
module sscd_step
	import sscd_pkg::*;
(
	input  logic [1:0] func,
	input  logic [2:0] sector,
	input  logic [1:0] direction,
	input  logic [7:0] duty,
	input  prod_t      prod,
	input  phase_t     last_high,
	input  phase_t     last_low,
	output step_res_t  res
);

	logic              good;
	logic              was_driven;
	logic [2:0]        idx;
	phase_t            next_high;
	phase_t            next_low;
	logic [PROD_W:0]   sum;
	logic [PROD_W-8:0] q_est;
	logic [PROD_W:0]   q_x255;
	logic [PROD_W:0]   rem;
	logic [PROD_W-8:0] q_fix;

	// divide by 255: x/256 + x/65536 + x/2^24 lands at most one short
	assign sum    = {1'b0, prod} + {9'b0, prod[PROD_W-1:8]} + {17'b0, prod[PROD_W-1:16]};
	assign q_est  = sum[PROD_W:8];
	assign q_x255 = {q_est, 8'b0} - {8'b0, q_est};
	assign rem    = {1'b0, prod} - q_x255;
	assign q_fix  = q_est + {{(PROD_W-8){1'b0}}, (rem >= 25'd255)};

	assign good       = (sector < SECTORS) && (direction != DIR_ZERO) && (duty != 8'd0);
	assign was_driven = (last_high != PHASE_NONE) || (last_low != PHASE_NONE);

	// reverse runs the forward table half a turn on
	always_comb begin
		if (direction == DIR_FWD) begin
			idx = sector;
		end else if (sector < HALF_TURN) begin
			idx = sector + HALF_TURN;
		end else begin
			idx = sector - HALF_TURN;
		end
	end

	assign next_high = pwm_phase_of(idx);
	assign next_low  = low_phase_of(idx);

	always_comb begin
		res.high    = PHASE_NONE;
		res.low     = PHASE_NONE;
		res.compare = 16'd0;
		res.duty    = 8'd0;
		res.oe_set  = 1'b0;
		res.oe_clr  = 1'b0;
		res.changed = was_driven;
		case (func)
			FUNC_STEP: begin
				if (good) begin
					res.high    = next_high;
					res.low     = next_low;
					res.compare = q_fix[15:0];
					res.duty    = duty;
					res.oe_set  = 1'b1;
					res.changed = !((next_high == last_high) && (next_low == last_low));
				end
			end
			FUNC_COAST: begin
				res.oe_clr = 1'b0;
			end
			FUNC_FAULT: begin
				res.oe_clr = 1'b1;
			end
			default: begin
				res.oe_clr = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/six_step_commutation_driver_top.sv =====
// ----------------------------------------------------------------------------
// six_step_commutation_driver_top
// an accepted command word passes the stage one register, then the result register;
// throughput: one word per cycle while out_stall is low; stage one forms duty * (reload + 1),
// stage two divides by 255, looks up the sector table and updates state
// reset: phases none, output enable set, reload 4799
// ----------------------------------------------------------------------------
`include "six_step_commutation_driver_top_macros.svh"

module six_step_commutation_driver_top
	import sscd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	input  logic [2:0]        sector,
	input  logic signed [1:0] direction,
	input  logic [7:0]        duty,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        phase_a_drive,
	output logic [1:0]        phase_b_drive,
	output logic [1:0]        phase_c_drive,
	output logic [15:0]       compare_ticks,
	output logic [7:0]        duty_applied,
	output logic              main_output_enable,
	output logic              drive_changed,
	input  logic              auto_reload_we,
	input  logic [15:0]       auto_reload_wdata
);

	logic [15:0] auto_reload_q;
	phase_t      last_high_q;
	phase_t      last_low_q;
	logic        oe_q;

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [2:0]  sector_s1;
	logic [1:0]  dir_s1;
	logic [7:0]  duty_s1;
	prod_t       prod_s1;

	logic        valid_s2;
	drive_t      drive_a_s2;
	drive_t      drive_b_s2;
	drive_t      drive_c_s2;
	logic [15:0] compare_s2;
	logic [7:0]  duty_s2;
	logic        oe_s2;
	logic        changed_s2;

	logic        s2_ready;
	logic        adv;
	logic        in_fire;
	logic [7:0]  duty_clamp;
	logic [16:0] reload_p1;
	logic [PROD_W:0] prod_full;
	logic        oe_next;
	step_res_t   res;

	assign s2_ready = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && s2_ready;
	assign in_stall = valid_s1 && !s2_ready;
	assign in_fire  = in_valid && !in_stall;

	assign duty_clamp = (duty > DUTY_MAX) ? DUTY_MAX : duty;
	assign reload_p1  = {1'b0, auto_reload_q} + 17'd1;
	assign prod_full  = {17'b0, duty_clamp} * {8'b0, reload_p1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_reload_q <= AUTO_RELOAD_RST;
		end else if (auto_reload_we) begin
			auto_reload_q <= auto_reload_wdata;
		end
	end

	// stage one: command word and product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1   <= func;
			sector_s1 <= sector;
			dir_s1    <= direction;
			duty_s1   <= duty_clamp;
			prod_s1   <= prod_full[PROD_W-1:0];
		end
	end

	sscd_step u_step (
		.func      (func_s1),
		.sector    (sector_s1),
		.direction (dir_s1),
		.duty      (duty_s1),
		.prod      (prod_s1),
		.last_high (last_high_q),
		.last_low  (last_low_q),
		.res       (res)
	);

	always_comb begin
		if (res.oe_set) begin
			oe_next = 1'b1;
		end else if (res.oe_clr) begin
			oe_next = 1'b0;
		end else begin
			oe_next = oe_q;
		end
	end

	// drive state moves only when a word enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_high_q <= PHASE_NONE;
			last_low_q  <= PHASE_NONE;
			oe_q        <= 1'b1;
		end else if (adv) begin
			last_high_q <= res.high;
			last_low_q  <= res.low;
			oe_q        <= oe_next;
		end
	end

	// stage two: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_a_s2 <= phase_mode(res.high, res.low, PHASE_A);
			drive_b_s2 <= phase_mode(res.high, res.low, PHASE_B);
			drive_c_s2 <= phase_mode(res.high, res.low, PHASE_C);
			compare_s2 <= res.compare;
			duty_s2    <= res.duty;
			oe_s2      <= oe_next;
			changed_s2 <= res.changed;
		end
	end

	assign out_valid          = valid_s2;
	assign phase_a_drive      = drive_a_s2;
	assign phase_b_drive      = drive_b_s2;
	assign phase_c_drive      = drive_c_s2;
	assign compare_ticks      = compare_s2;
	assign duty_applied       = duty_s2;
	assign main_output_enable = oe_s2;
	assign drive_changed      = changed_s2;

	`SSCD_ASSERT_NOW(a_off_floats, clk, arst_n,
		out_valid && (duty_applied == 8'd0),
		(drive_a_s2 == DRV_FLOAT) && (drive_b_s2 == DRV_FLOAT) && (drive_c_s2 == DRV_FLOAT),
		"zero duty with a phase still driven")
	`SSCD_ASSERT_NOW(a_one_pwm, clk, arst_n,
		out_valid && (duty_applied != 8'd0),
		($countones({drive_a_s2 == DRV_PWM, drive_b_s2 == DRV_PWM, drive_c_s2 == DRV_PWM}) == 1)
		&& ($countones({drive_a_s2 == DRV_LOW, drive_b_s2 == DRV_LOW,
		drive_c_s2 == DRV_LOW}) == 1),
		"step pattern needs one pwm phase and one low phase")
	`SSCD_ASSERT_NOW(a_oe_off, clk, arst_n,
		out_valid && !main_output_enable,
		duty_applied == 8'd0,
		"gate enable cleared while a step is applied")
	`SSCD_ASSERT_NEXT(a_s1_hold, clk, arst_n,
		valid_s1 && !s2_ready,
		valid_s1,
		"stage one word lost while the result register is blocked")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the six-step commutation driver: a short table of
// directed command words, then random words over several reload settings,
// every result word checked field by field against typed values or a local commutation model
// ----------------------------------------------------------------------------
module testbench;
	import sscd_pkg::*;

	localparam logic [1:0] FUNC_SPARE  = 2'd3;
	localparam logic [1:0] DIR_REV     = 2'b11;
	localparam logic [1:0] DIR_REV_ALT = 2'b10;
	localparam int unsigned DUTY_DEN   = 255;
	localparam int PHASE_ITEMS = 250;
	localparam int N_DIRECTED  = 25;

	typedef struct packed {
		logic [1:0] fn;
		logic [2:0] sec;
		logic [1:0] dir;
		logic [7:0] dty;
	} cmd_t;

	typedef struct packed {
		drive_t      pa;
		drive_t      pb;
		drive_t      pc;
		logic [15:0] cmp;
		logic [7:0]  dap;
		logic        moe;
		logic        chg;
	} drive_word_t;

	typedef struct packed {
		cmd_t        cmd;
		logic        known;
		drive_word_t want;
	} row_t;

	// forward commutation order, index is the sector
	localparam phase_t HI_TAB [6] = '{PHASE_B, PHASE_C, PHASE_C, PHASE_A, PHASE_A, PHASE_B};
	localparam phase_t LO_TAB [6] = '{PHASE_A, PHASE_A, PHASE_B, PHASE_B, PHASE_C, PHASE_C};

	// reset reload throughout; expectations typed in only where obvious
	localparam row_t DIRECTED [N_DIRECTED] = '{
		'{'{FUNC_COAST, 3'd0, DIR_FWD, 8'd100}, 1'b1,
			'{DRV_FLOAT, DRV_FLOAT, DRV_FLOAT, 16'd0, 8'd0, 1'b1, 1'b0}},
		'{'{FUNC_STEP, 3'd0, DIR_FWD, 8'd255}, 1'b1,
			'{DRV_LOW, DRV_PWM, DRV_FLOAT, 16'd4705, 8'd250, 1'b1, 1'b1}},
		'{'{FUNC_STEP, 3'd0, DIR_FWD, 8'd250}, 1'b1,
			'{DRV_LOW, DRV_PWM, DRV_FLOAT, 16'd4705, 8'd250, 1'b1, 1'b0}},
		'{'{FUNC_STEP, 3'd1, DIR_FWD, 8'd1}, 1'b0, '0},
		'{'{FUNC_STEP, 3'd2, DIR_FWD, 8'd128}, 1'b0, '0},
		'{'{FUNC_STEP, 3'd3, DIR_FWD, 8'd251}, 1'b0, '0},
		'{'{FUNC_STEP, 3'd4, DIR_FWD, 8'd249}, 1'b0, '0},
		'{'{FUNC_STEP, 3'd5, DIR_FWD, 8'd64}, 1'b0, '0},
		'{'{FUNC_STEP, 3'd0, DIR_REV, 8'd200}, 1'b0, '0},
		'{'{FUNC_STEP, 3'd5, DIR_REV_ALT, 8'd255}, 1'b0, '0},
		'{'{FUNC_STEP, 3'd2, DIR_REV, 8'd7}, 1'b0, '0},
		'{'{FUNC_STEP, 3'd6, DIR_FWD, 8'd100}, 1'b1,
			'{DRV_FLOAT, DRV_FLOAT, DRV_FLOAT, 16'd0, 8'd0, 1'b1, 1'b1}},
		'{'{FUNC_STEP, 3'd7, DIR_REV, 8'd255}, 1'b1,
			'{DRV_FLOAT, DRV_FLOAT, DRV_FLOAT, 16'd0, 8'd0, 1'b1, 1'b0}},
		'{'{FUNC_STEP, 3'd4, DIR_FWD, 8'd10}, 1'b0, '0},
		'{'{FUNC_STEP, 3'd4, DIR_FWD, 8'd0}, 1'b1,
			'{DRV_FLOAT, DRV_FLOAT, DRV_FLOAT, 16'd0, 8'd0, 1'b1, 1'b1}},
		'{'{FUNC_STEP, 3'd1, DIR_FWD, 8'd90}, 1'b0, '0},
		'{'{FUNC_STEP, 3'd1, DIR_ZERO, 8'd90}, 1'b1,
			'{DRV_FLOAT, DRV_FLOAT, DRV_FLOAT, 16'd0, 8'd0, 1'b1, 1'b1}},
		'{'{FUNC_STEP, 3'd3, DIR_REV, 8'd255}, 1'b0, '0},
		'{'{FUNC_FAULT, 3'd3, DIR_REV, 8'd255}, 1'b1,
			'{DRV_FLOAT, DRV_FLOAT, DRV_FLOAT, 16'd0, 8'd0, 1'b0, 1'b1}},
		'{'{FUNC_STEP, 3'd0, DIR_ZERO, 8'd255}, 1'b1,
			'{DRV_FLOAT, DRV_FLOAT, DRV_FLOAT, 16'd0, 8'd0, 1'b0, 1'b0}},
		'{'{FUNC_FAULT, 3'd0, DIR_FWD, 8'd0}, 1'b1,
			'{DRV_FLOAT, DRV_FLOAT, DRV_FLOAT, 16'd0, 8'd0, 1'b0, 1'b0}},
		'{'{FUNC_STEP, 3'd2, DIR_FWD, 8'd255}, 1'b0, '0},
		'{'{FUNC_SPARE, 3'd7, DIR_REV_ALT, 8'd0}, 1'b1,
			'{DRV_FLOAT, DRV_FLOAT, DRV_FLOAT, 16'd0, 8'd0, 1'b1, 1'b1}},
		'{'{FUNC_COAST, 3'd5, DIR_REV, 8'd255}, 1'b1,
			'{DRV_FLOAT, DRV_FLOAT, DRV_FLOAT, 16'd0, 8'd0, 1'b1, 1'b0}},
		'{'{FUNC_STEP, 3'd3, DIR_REV_ALT, 8'd255}, 1'b0, '0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        func = FUNC_COAST;
	logic [2:0]        sector = 3'd0;
	logic signed [1:0] direction = 2'sd0;
	logic [7:0]        duty = 8'd0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        phase_a_drive;
	logic [1:0]        phase_b_drive;
	logic [1:0]        phase_c_drive;
	logic [15:0]       compare_ticks;
	logic [7:0]        duty_applied;
	logic              main_output_enable;
	logic              drive_changed;
	logic              auto_reload_we = 1'b0;
	logic [15:0]       auto_reload_wdata = 16'd0;

	six_step_commutation_driver_top u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.func               (func),
		.sector             (sector),
		.direction          (direction),
		.duty               (duty),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.phase_a_drive      (phase_a_drive),
		.phase_b_drive      (phase_b_drive),
		.phase_c_drive      (phase_c_drive),
		.compare_ticks      (compare_ticks),
		.duty_applied       (duty_applied),
		.main_output_enable (main_output_enable),
		.drive_changed      (drive_changed),
		.auto_reload_we     (auto_reload_we),
		.auto_reload_wdata  (auto_reload_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model state of the commutation logic
	phase_t      cur_high = PHASE_NONE;
	phase_t      cur_low = PHASE_NONE;
	logic [7:0]  cur_duty = 8'd0;
	logic [15:0] cur_cmp = 16'd0;
	logic        cur_oe = 1'b1;
	logic [15:0] reload_shadow = AUTO_RELOAD_RST;

	drive_word_t pending_drive [$];
	int          fail_count = 0;
	int          burst_left = 0;
	cmd_t        prev_cmd = '0;

	function automatic drive_word_t commutate(cmd_t c);
		drive_word_t w;
		drive_t      m [3];
		int unsigned d;
		int unsigned idx;
		phase_t      nh;
		phase_t      nl;
		logic        was_on;
		was_on = (cur_high != PHASE_NONE) || (cur_low != PHASE_NONE);
		if (c.fn == FUNC_STEP && c.sec < SECTORS && c.dir != DIR_ZERO && c.dty != 8'd0) begin
			d = (c.dty > DUTY_MAX) ? int'(DUTY_MAX) : int'(c.dty);
			// reverse runs the forward table half a turn on
			idx = (c.dir == DIR_FWD) ? int'(c.sec)
				: (int'(c.sec) + int'(HALF_TURN)) % int'(SECTORS);
			nh = HI_TAB[idx];
			nl = LO_TAB[idx];
			w.chg = !(nh == cur_high && nl == cur_low);
			cur_high = nh;
			cur_low = nl;
			cur_oe = 1'b1;
			cur_duty = d[7:0];
			d = (d * (int'(reload_shadow) + 1)) / DUTY_DEN;
			cur_cmp = d[15:0];
		end else begin
			w.chg = was_on;
			cur_high = PHASE_NONE;
			cur_low = PHASE_NONE;
			cur_duty = 8'd0;
			cur_cmp = 16'd0;
			if (c.fn == FUNC_FAULT) begin
				cur_oe = 1'b0;
			end
		end
		for (int p = 0; p < 3; p++) begin
			m[p] = (cur_high == phase_t'(p)) ? DRV_PWM
				: (cur_low == phase_t'(p)) ? DRV_LOW : DRV_FLOAT;
		end
		w.pa = m[0];
		w.pb = m[1];
		w.pc = m[2];
		w.cmp = cur_cmp;
		w.dap = cur_duty;
		w.moe = cur_oe;
		return w;
	endfunction

	// mostly good steps, often repeating the last pattern, with some noise
	function automatic cmd_t random_cmd();
		cmd_t c;
		int   r;
		r = $urandom_range(0, 99);
		c.fn = (r < 75) ? FUNC_STEP : (r < 85) ? FUNC_COAST : (r < 93) ? FUNC_FAULT : FUNC_SPARE;
		if ($urandom_range(0, 9) < 3) begin
			c.sec = prev_cmd.sec;
			c.dir = prev_cmd.dir;
		end else begin
			c.sec = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 5))
				: 3'($urandom_range(6, 7));
			r = $urandom_range(0, 15);
			c.dir = (r == 0) ? DIR_ZERO : (r < 8) ? DIR_FWD : (r < 13) ? DIR_REV : DIR_REV_ALT;
		end
		r = $urandom_range(0, 15);
		c.dty = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : (r == 2) ? 8'($urandom_range(250, 255))
			: 8'($urandom_range(1, 255));
		prev_cmd = c;
		return c;
	endfunction

	// present one command word, with a random gap between bursts
	task automatic put_word(cmd_t c, logic known, drive_word_t typed);
		drive_word_t w;
		int          gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		func <= c.fn;
		sector <= c.sec;
		direction <= c.dir;
		duty <= c.dty;
		do @(posedge clk); while (in_stall);
		w = commutate(c);
		pending_drive.push_back(known ? typed : w);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_drive.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reload(logic [15:0] v);
		drain();
		auto_reload_we <= 1'b1;
		auto_reload_wdata <= v;
		@(posedge clk);
		auto_reload_we <= 1'b0;
		reload_shadow = v;
		burst_left = 0;
	endtask

	task automatic check_word();
		drive_word_t w;
		if (pending_drive.size() == 0) begin
			$error("result word with nothing expected");
			fail_count++;
		end else begin
			w = pending_drive.pop_front();
			if (w.pa != phase_a_drive) begin
				$error("phase_a_drive: expected %0d, got %0d", w.pa, phase_a_drive);
				fail_count++;
			end
			if (w.pb != phase_b_drive) begin
				$error("phase_b_drive: expected %0d, got %0d", w.pb, phase_b_drive);
				fail_count++;
			end
			if (w.pc != phase_c_drive) begin
				$error("phase_c_drive: expected %0d, got %0d", w.pc, phase_c_drive);
				fail_count++;
			end
			if (w.cmp != compare_ticks) begin
				$error("compare_ticks: expected %0d, got %0d", w.cmp, compare_ticks);
				fail_count++;
			end
			if (w.dap != duty_applied) begin
				$error("duty_applied: expected %0d, got %0d", w.dap, duty_applied);
				fail_count++;
			end
			if (w.moe != main_output_enable) begin
				$error("main_output_enable: expected %0d, got %0d", w.moe, main_output_enable);
				fail_count++;
			end
			if (w.chg != drive_changed) begin
				$error("drive_changed: expected %0d, got %0d", w.chg, drive_changed);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			check_word();
		end
	end

	// receiver back-pressure, switching between a few patterns
	int stall_mode = 0;
	int stall_left = 0;
	int stall_tick = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(64, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_tick <= stall_tick + 1;
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 2) == 0);
			end
			2: begin
				out_stall <= ((stall_tick % 5) < 2);
			end
			default: begin
				out_stall <= ($urandom_range(0, 2) != 0);
			end
		endcase
	end

	logic [15:0] reload_plan [6];

	initial begin
		reload_plan = '{16'd0, 16'hFFFF, AUTO_RELOAD_RST, 16'd254, 16'd255,
			16'($urandom_range(0, 65535))};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++) begin
			put_word(DIRECTED[i].cmd, DIRECTED[i].known, DIRECTED[i].want);
		end
		foreach (reload_plan[k]) begin
			set_reload(reload_plan[k]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				put_word(random_cmd(), 1'b0, '0);
			end
		end
		drain();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending_drive.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
